// ===== rtl/sbc_pkg.sv =====
// Shared types and constants for the swept box collision pipeline.
`timescale 1ns / 1ps
package sbc_pkg;

    localparam int VEL_W     = 24;
    localparam int FRAME_W   = 16;
    localparam int FRAMEQ_W  = 24;
    localparam int TOL_W     = 16;
    localparam int ENTRY_W   = 24;
    localparam int NRM_W     = 3;
    localparam int TLIM_BITS = 40;
    localparam int TIME_W    = 42;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd512;

    localparam logic [NRM_W-1:0] NRM_NONE   = 3'd0;
    localparam logic [NRM_W-1:0] NRM_DOWN   = 3'd1;
    localparam logic [NRM_W-1:0] NRM_UP     = 3'd2;
    localparam logic [NRM_W-1:0] NRM_RIGHT  = 3'd3;
    localparam logic [NRM_W-1:0] NRM_LEFT   = 3'd4;
    localparam logic [NRM_W-1:0] NRM_INSIDE = 3'd5;

    typedef struct packed {
        logic                x_open;
        logic                y_open;
        logic                overlap;
        logic                close_bot;
        logic                close_top;
        logic                close_r;
        logic                close_l_le;
        logic                close_l_lt;
        logic                vx_pos;
        logic                vx_zero;
        logic                vy_pos;
        logic                vy_zero;
        logic [FRAMEQ_W-1:0] frame;
    } t_side;

endpackage

// ===== rtl/sbc_prep.sv =====
// Front stage: box edges, sweep distances, overlap and contact flags.
`timescale 1ns / 1ps
module sbc_prep #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [COORD_BITS-1:0]       i_ax,
    input  logic signed [COORD_BITS-1:0]       i_ay,
    input  logic        [COORD_BITS-2:0]       i_aw,
    input  logic        [COORD_BITS-2:0]       i_ah,
    input  logic signed [sbc_pkg::VEL_W-1:0]   i_vx,
    input  logic signed [sbc_pkg::VEL_W-1:0]   i_vy,
    input  logic signed [COORD_BITS-1:0]       i_bx,
    input  logic signed [COORD_BITS-1:0]       i_by,
    input  logic        [COORD_BITS-2:0]       i_bw,
    input  logic        [COORD_BITS-2:0]       i_bh,
    input  logic        [sbc_pkg::FRAME_W-1:0] i_frame,
    input  logic        [sbc_pkg::TOL_W-1:0]   i_tol,
    output logic        [COORD_BITS+1:0]       o_mag_xin,
    output logic        [COORD_BITS+1:0]       o_mag_xout,
    output logic        [COORD_BITS+1:0]       o_mag_yin,
    output logic        [COORD_BITS+1:0]       o_mag_yout,
    output logic        [3:0]                  o_neg,
    output logic        [sbc_pkg::VEL_W-1:0]   o_avx,
    output logic        [sbc_pkg::VEL_W-1:0]   o_avy,
    output sbc_pkg::t_side                     o_side
);
    import sbc_pkg::*;

    localparam int DW   = COORD_BITS + 2;
    localparam int TFW  = TOL_W + 8;
    localparam int CMPW = DW + TFW;
    localparam int SH_L = (FRAC_BITS >= 8) ? (FRAC_BITS - 8) : 0;
    localparam int SH_R = (FRAC_BITS >= 8) ? 0 : (8 - FRAC_BITS);

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] n;
        n = -v;
        return v[DW-1] ? n : v;
    endfunction

    logic signed [DW-1:0] ax, ay, bx, by, a_r, a_b, b_r, b_b;
    logic signed [DW-1:0] xin, xout, yin, yout;
    logic [TFW-1:0]       tol_f;
    logic [CMPW-1:0]      tol_c, d_bot, d_top, d_r, d_l;
    logic                 vx_neg, vy_neg;
    logic signed [VEL_W:0] nvx, nvy;
    t_side                side;

    logic [DW-1:0]    r_mag_xin, r_mag_xout, r_mag_yin, r_mag_yout;
    logic [3:0]       r_neg;
    logic [VEL_W-1:0] r_avx, r_avy;
    t_side            r_side;

    always_comb begin
        ax  = {{2{i_ax[COORD_BITS-1]}}, i_ax};
        ay  = {{2{i_ay[COORD_BITS-1]}}, i_ay};
        bx  = {{2{i_bx[COORD_BITS-1]}}, i_bx};
        by  = {{2{i_by[COORD_BITS-1]}}, i_by};
        a_r = ax + $signed({3'b000, i_aw});
        a_b = ay - $signed({3'b000, i_ah});
        b_r = bx + $signed({3'b000, i_bw});
        b_b = by - $signed({3'b000, i_bh});

        vx_neg = i_vx[VEL_W-1];
        vy_neg = i_vy[VEL_W-1];
        if (!vx_neg && i_vx != '0) begin
            xin = bx - a_r; xout = b_r - ax;
        end else begin
            xin = b_r - ax; xout = bx - a_r;
        end
        if (!vy_neg && i_vy != '0) begin
            yin = b_b - ay; yout = by - a_b;
        end else begin
            yin = by - a_b; yout = b_b - ay;
        end

        tol_f = (FRAC_BITS >= 8) ? ({8'd0, i_tol} << SH_L) : ({8'd0, i_tol} >> SH_R);
        tol_c = {{DW{1'b0}}, tol_f};
        d_bot = {{TFW{1'b0}}, mag(a_b - by)};
        d_top = {{TFW{1'b0}}, mag(ay - b_b)};
        d_r   = {{TFW{1'b0}}, mag(a_r - bx)};
        d_l   = {{TFW{1'b0}}, mag(ax - b_r)};

        side.x_open     = !(a_r <= bx || ax >= b_r);
        side.y_open     = !(a_b >= by || ay <= b_b);
        side.overlap    = !(ax > b_r || ay < b_b || a_r < bx || a_b > by);
        side.close_bot  = d_bot <= tol_c;
        side.close_top  = d_top <= tol_c;
        side.close_r    = d_r <= tol_c;
        side.close_l_le = d_l <= tol_c;
        side.close_l_lt = d_l < tol_c;
        side.vx_zero    = i_vx == '0;
        side.vy_zero    = i_vy == '0;
        side.vx_pos     = !vx_neg && !side.vx_zero;
        side.vy_pos     = !vy_neg && !side.vy_zero;
        side.frame      = {i_frame, 8'd0};

        nvx = -$signed({i_vx[VEL_W-1], i_vx});
        nvy = -$signed({i_vy[VEL_W-1], i_vy});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_xin  <= mag(xin);
            r_mag_xout <= mag(xout);
            r_mag_yin  <= mag(yin);
            r_mag_yout <= mag(yout);
            r_neg      <= {yout[DW-1] ^ vy_neg, yin[DW-1] ^ vy_neg,
                           xout[DW-1] ^ vx_neg, xin[DW-1] ^ vx_neg};
            r_avx      <= vx_neg ? nvx[VEL_W-1:0] : i_vx;
            r_avy      <= vy_neg ? nvy[VEL_W-1:0] : i_vy;
            r_side     <= side;
        end
    end

    assign o_mag_xin  = r_mag_xin;
    assign o_mag_xout = r_mag_xout;
    assign o_mag_yin  = r_mag_yin;
    assign o_mag_yout = r_mag_yout;
    assign o_neg      = r_neg;
    assign o_avx      = r_avx;
    assign o_avy      = r_avy;
    assign o_side     = r_side;

endmodule

// ===== rtl/sbc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module sbc_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 24
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic             i_neg,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_neg
);
    logic [DEN_W-1:0] r_rem [0:NUM_W-1];
    logic [NUM_W-1:0] r_num [0:NUM_W-1];
    logic [NUM_W-1:0] r_quo [0:NUM_W-1];
    logic [DEN_W-1:0] r_den [0:NUM_W-1];
    logic             r_neg [0:NUM_W-1];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] p_rem, p_den, n_rem;
        logic [NUM_W-1:0] p_num, p_quo;
        logic             p_neg, ge;
        logic [DEN_W:0]   trial, diff;

        if (k == 0) begin : g_first
            assign p_rem = '0;
            assign p_num = i_num;
            assign p_quo = '0;
            assign p_den = i_den;
            assign p_neg = i_neg;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_num = r_num[k-1];
            assign p_quo = r_quo[k-1];
            assign p_den = r_den[k-1];
            assign p_neg = r_neg[k-1];
        end

        always_comb begin
            trial = {p_rem, p_num[NUM_W-1]};
            diff  = trial - {1'b0, p_den};
            ge    = trial >= {1'b0, p_den};
            n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_num[k] <= {p_num[NUM_W-2:0], 1'b0};
                r_quo[k] <= {p_quo[NUM_W-2:0], ge};
                r_den[k] <= p_den;
                r_neg[k] <= p_neg;
            end
        end
    end

    assign o_quo = r_quo[NUM_W-1];
    assign o_neg = r_neg[NUM_W-1];

endmodule

// ===== rtl/sbc_decide.sv =====
// Back stages: signed times, entry and exit, hit test and contact normals.
`timescale 1ns / 1ps
module sbc_decide #(
    parameter int NUM_W = 50
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [NUM_W-1:0]              i_q_xin,
    input  logic [NUM_W-1:0]              i_q_xout,
    input  logic [NUM_W-1:0]              i_q_yin,
    input  logic [NUM_W-1:0]              i_q_yout,
    input  logic [3:0]                    i_neg,
    input  sbc_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [sbc_pkg::ENTRY_W-1:0]   o_entry,
    output logic [sbc_pkg::NRM_W-1:0]     o_nx,
    output logic [sbc_pkg::NRM_W-1:0]     o_ny,
    output logic                          o_hit
);
    import sbc_pkg::*;

    localparam int QX = 72;
    localparam logic signed [TIME_W-1:0] T_LIM = TIME_W'(64'd1 << TLIM_BITS);

    function automatic logic signed [TIME_W-1:0] to_time(input logic [NUM_W-1:0] q,
                                                          input logic neg);
        logic [QX-1:0]     qx;
        logic [TIME_W-1:0] m;
        qx = {{(QX-NUM_W){1'b0}}, q};
        if (qx[QX-1:TLIM_BITS] != '0)
            m = {2'b00, {TLIM_BITS{1'b1}}};
        else
            m = {2'b00, qx[TLIM_BITS-1:0]};
        return neg ? -$signed(m) : $signed(m);
    endfunction

    logic signed [TIME_W-1:0] xe, xx, ye, yx, entry, exit_t, frame;

    logic                     r_vld1, r_miss, r_xgt;
    logic signed [TIME_W-1:0] r_entry;
    t_side                    r_side;

    logic                     r_vld;
    logic [ENTRY_W-1:0]       r_out_entry;
    logic [NRM_W-1:0]         r_nx, r_ny;
    logic                     r_hit;

    logic [NRM_W-1:0]         n_nx, n_ny;
    logic                     n_hit;
    logic signed [TIME_W-1:0] n_t;

    always_comb begin
        xe     = i_side.vx_zero ? -T_LIM : to_time(i_q_xin, i_neg[0]);
        xx     = i_side.vx_zero ?  T_LIM : to_time(i_q_xout, i_neg[1]);
        ye     = i_side.vy_zero ? -T_LIM : to_time(i_q_yin, i_neg[2]);
        yx     = i_side.vy_zero ?  T_LIM : to_time(i_q_yout, i_neg[3]);
        entry  = (xe > ye) ? xe : ye;
        exit_t = (xx < yx) ? xx : yx;
        frame  = $signed({{(TIME_W-FRAMEQ_W){1'b0}}, i_side.frame});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_miss  <= entry > exit_t || (xe < 0 && ye < 0) || xe > frame || ye > frame;
            r_xgt   <= xe > ye;
            r_entry <= entry;
            r_side  <= i_side;
        end
    end

    always_comb begin
        n_nx  = NRM_NONE;
        n_ny  = NRM_NONE;
        n_hit = 1'b0;
        n_t   = '0;
        if (r_miss) begin
            if (r_side.overlap) begin
                priority if (r_side.close_bot && r_side.x_open) n_ny = NRM_DOWN;
                else if (r_side.close_top && r_side.x_open) n_ny = NRM_UP;
                else if (r_side.close_r && r_side.y_open) n_nx = NRM_RIGHT;
                else if (r_side.close_l_le && r_side.y_open) n_nx = NRM_LEFT;
                else if (r_side.x_open && r_side.y_open) begin
                    n_nx = NRM_INSIDE;
                    n_ny = NRM_INSIDE;
                end else n_nx = NRM_NONE;
            end
        end else begin
            n_hit = 1'b1;
            n_t   = r_entry;
            if (r_xgt) begin
                priority if (r_side.y_open) begin
                    n_nx = r_side.vx_pos ? NRM_RIGHT : NRM_LEFT;
                end else if (r_side.close_bot) begin
                    n_ny = NRM_DOWN;
                    n_t  = '0;
                end else if (r_side.close_top) begin
                    n_ny = NRM_UP;
                    n_t  = '0;
                end else begin
                    n_ny = NRM_NONE;
                end
            end else begin
                priority if (r_side.x_open) begin
                    n_ny = r_side.vy_pos ? NRM_UP : NRM_DOWN;
                end else if (r_side.close_r) begin
                    n_nx = NRM_RIGHT;
                    n_t  = '0;
                end else if (r_side.close_l_lt) begin
                    n_nx = NRM_LEFT;
                    n_t  = '0;
                end else begin
                    n_nx = NRM_NONE;
                end
            end
        end
        if (n_t < 0)
            n_t = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_entry <= n_t[ENTRY_W-1:0];
            r_nx        <= n_nx;
            r_ny        <= n_ny;
            r_hit       <= n_hit;
        end
    end

    assign o_valid = r_vld;
    assign o_entry = r_out_entry;
    assign o_nx    = r_nx;
    assign o_ny    = r_ny;
    assign o_hit   = r_hit;

endmodule

// ===== rtl/swept_box_collision.sv =====
// Top level of the swept box collision pipeline.
`timescale 1ns / 1ps
// Sweeps a moving box against a static box over one frame and returns the
// entry time (Q8.16), a contact normal per axis and a hit flag. One
// transaction is accepted per cycle while the output is not stalled. The pipeline has
// one front stage, one stage per quotient bit in the four time dividers
// (COORD_BITS + 34 - FRAC_BITS bits), and two back stages. A stall at the output
// holds the whole pipeline. The user must write the contact tolerance through
// i_cfg_we / i_cfg_wdata only while the pipe is empty; the block does not check it.
module swept_box_collision #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // a_x, a_y, a_width, a_height, a_vel_x, a_vel_y, b_x, b_y, b_width,
    // b_height, frame_time, zero pad
    input  logic [((8*COORD_BITS+60+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // entry_time, normal_x, normal_y, zero pad
    output logic [31:0]           o_m_axis_tdata,
    // hit
    output logic                  o_m_axis_tuser
);
    import sbc_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int DW    = C + 2;
    localparam int SH    = 32 - FRAC_BITS;
    localparam int NUM_W = DW + SH;
    localparam int O_AY  = C;
    localparam int O_AW  = 2 * C;
    localparam int O_AH  = 3 * C - 1;
    localparam int O_VX  = 4 * C - 2;
    localparam int O_VY  = O_VX + VEL_W;
    localparam int O_BX  = O_VY + VEL_W;
    localparam int O_BY  = O_BX + C;
    localparam int O_BW  = O_BY + C;
    localparam int O_BH  = O_BW + C - 1;
    localparam int O_FT  = O_BH + C - 1;

    logic               en;
    logic [TOL_W-1:0]   r_tol;
    logic               r_vld0;

    logic [DW-1:0]      mag_xin, mag_xout, mag_yin, mag_yout;
    logic [3:0]         neg_p, neg_d;
    logic [VEL_W-1:0]   avx, avy;
    t_side              side_p;
    logic [NUM_W-1:0]   q_xin, q_xout, q_yin, q_yout;

    t_side              r_side_dly [0:NUM_W-1];
    logic               r_vld_dly  [0:NUM_W-1];

    logic               out_vld, out_hit;
    logic [ENTRY_W-1:0] out_entry;
    logic [NRM_W-1:0]   out_nx, out_ny;

    assign en              = !out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            for (int k = 0; k < NUM_W; k++) r_vld_dly[k] <= 1'b0;
        end else if (en) begin
            r_vld0       <= i_s_axis_tvalid;
            r_vld_dly[0] <= r_vld0;
            for (int k = 1; k < NUM_W; k++) r_vld_dly[k] <= r_vld_dly[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side_dly[0] <= side_p;
            for (int k = 1; k < NUM_W; k++) r_side_dly[k] <= r_side_dly[k-1];
        end
    end

    sbc_prep #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_prep (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_ax       ($signed(i_s_axis_tdata[O_AY-1:0])),
        .i_ay       ($signed(i_s_axis_tdata[O_AW-1:O_AY])),
        .i_aw       (i_s_axis_tdata[O_AH-1:O_AW]),
        .i_ah       (i_s_axis_tdata[O_VX-1:O_AH]),
        .i_vx       ($signed(i_s_axis_tdata[O_VY-1:O_VX])),
        .i_vy       ($signed(i_s_axis_tdata[O_BX-1:O_VY])),
        .i_bx       ($signed(i_s_axis_tdata[O_BY-1:O_BX])),
        .i_by       ($signed(i_s_axis_tdata[O_BW-1:O_BY])),
        .i_bw       (i_s_axis_tdata[O_BH-1:O_BW]),
        .i_bh       (i_s_axis_tdata[O_FT-1:O_BH]),
        .i_frame    (i_s_axis_tdata[O_FT+FRAME_W-1:O_FT]),
        .i_tol      (r_tol),
        .o_mag_xin  (mag_xin),
        .o_mag_xout (mag_xout),
        .o_mag_yin  (mag_yin),
        .o_mag_yout (mag_yout),
        .o_neg      (neg_p),
        .o_avx      (avx),
        .o_avy      (avy),
        .o_side     (side_p)
    );

    sbc_div #(.NUM_W(NUM_W), .DEN_W(VEL_W)) u_div_xin (
        .i_clk (i_clk), .i_en (en), .i_num ({mag_xin, {SH{1'b0}}}), .i_den (avx),
        .i_neg (neg_p[0]), .o_quo (q_xin), .o_neg (neg_d[0])
    );

    sbc_div #(.NUM_W(NUM_W), .DEN_W(VEL_W)) u_div_xout (
        .i_clk (i_clk), .i_en (en), .i_num ({mag_xout, {SH{1'b0}}}), .i_den (avx),
        .i_neg (neg_p[1]), .o_quo (q_xout), .o_neg (neg_d[1])
    );

    sbc_div #(.NUM_W(NUM_W), .DEN_W(VEL_W)) u_div_yin (
        .i_clk (i_clk), .i_en (en), .i_num ({mag_yin, {SH{1'b0}}}), .i_den (avy),
        .i_neg (neg_p[2]), .o_quo (q_yin), .o_neg (neg_d[2])
    );

    sbc_div #(.NUM_W(NUM_W), .DEN_W(VEL_W)) u_div_yout (
        .i_clk (i_clk), .i_en (en), .i_num ({mag_yout, {SH{1'b0}}}), .i_den (avy),
        .i_neg (neg_p[3]), .o_quo (q_yout), .o_neg (neg_d[3])
    );

    sbc_decide #(.NUM_W(NUM_W)) u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_vld_dly[NUM_W-1]),
        .i_q_xin  (q_xin),
        .i_q_xout (q_xout),
        .i_q_yin  (q_yin),
        .i_q_yout (q_yout),
        .i_neg    (neg_d),
        .i_side   (r_side_dly[NUM_W-1]),
        .o_valid  (out_vld),
        .o_entry  (out_entry),
        .o_nx     (out_nx),
        .o_ny     (out_ny),
        .o_hit    (out_hit)
    );

    assign o_m_axis_tvalid = out_vld;
    assign o_m_axis_tdata  = {2'b00, out_ny, out_nx, out_entry};
    assign o_m_axis_tuser  = out_hit;

endmodule
